// ----- rtl/bts_pkg.sv -----
// Shared constants, types and the lerp helper for the bilinear texture sampler.
// Used by every module of the block except bts_ram; depends on nothing.
`timescale 1ns / 1ps
package bts_pkg;

	localparam int COLS_LOG2  = 8;
	localparam int ROWS_LOG2  = 8;
	localparam int FRAC_BITS  = 16;
	localparam int DIM_W      = 9;
	localparam int BANK_AW    = (COLS_LOG2 - 1) + (ROWS_LOG2 - 1);
	localparam int TEXEL_W    = 24;
	localparam int S_DATA_W   = 104;
	localparam int M_DATA_W   = 24;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 2'd1;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [TEXEL_W-1:0] MAGENTA = 24'hFF00FF;

	typedef struct packed {
		logic [COLS_LOG2-1:0] x0;
		logic [COLS_LOG2-1:0] x1;
		logic [ROWS_LOG2-1:0] y0;
		logic [ROWS_LOG2-1:0] y1;
		logic [FRAC_BITS-1:0] tx;
		logic [FRAC_BITS-1:0] ty;
		logic                 empty;
	} coord_t;

	function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
			input logic [FRAC_BITS-1:0] t);
		logic [FRAC_BITS:0]   one_minus;
		logic [FRAC_BITS+8:0] acc;
		one_minus = (FRAC_BITS+1)'(1) << FRAC_BITS;
		one_minus = one_minus - {1'b0, t};
		acc = (FRAC_BITS+9)'(a) * (FRAC_BITS+9)'(one_minus) + (FRAC_BITS+9)'(b) * (FRAC_BITS+9)'(t);
		return acc[FRAC_BITS +: 8];
	endfunction

	function automatic logic [TEXEL_W-1:0] lerp_texel(input logic [TEXEL_W-1:0] p,
			input logic [TEXEL_W-1:0] q, input logic [FRAC_BITS-1:0] t);
		return {lerp8(p[23:16], q[23:16], t), lerp8(p[15:8], q[15:8], t),
			lerp8(p[7:0], q[7:0], t)};
	endfunction

endpackage

// ----- rtl/bts_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// One bank of the texel store; no dependencies.
`timescale 1ns / 1ps
module bts_ram #(
	parameter int AW = 14,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/bts_coord.sv -----
// Coordinate stage: scales the wrapped u and v by size-1, yields indices and weights.
// Depends on bts_pkg.
`timescale 1ns / 1ps
module bts_coord import bts_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] frac_u,
	input  logic [FRAC_BITS-1:0] frac_v,
	input  logic [DIM_W-1:0]     tex_width,
	input  logic [DIM_W-1:0]     tex_height,
	output coord_t               coord_s2
);

	localparam logic [DIM_W-1:0] MAX_COLS = DIM_W'(1) << COLS_LOG2;
	localparam logic [DIM_W-1:0] MAX_ROWS = DIM_W'(1) << ROWS_LOG2;

	logic [DIM_W-1:0]               w_sat, h_sat;
	logic [COLS_LOG2-1:0]           wm1;
	logic [ROWS_LOG2-1:0]           hm1;
	logic [FRAC_BITS+COLS_LOG2-1:0] scaled_u;
	logic [FRAC_BITS+ROWS_LOG2-1:0] scaled_v;
	coord_t                         c;

	always_comb begin
		w_sat = (tex_width > MAX_COLS) ? MAX_COLS : tex_width;
		h_sat = (tex_height > MAX_ROWS) ? MAX_ROWS : tex_height;
		wm1 = COLS_LOG2'(w_sat - DIM_W'(1));
		hm1 = ROWS_LOG2'(h_sat - DIM_W'(1));
		scaled_u = (FRAC_BITS+COLS_LOG2)'(frac_u) * (FRAC_BITS+COLS_LOG2)'(wm1);
		scaled_v = (FRAC_BITS+ROWS_LOG2)'(frac_v) * (FRAC_BITS+ROWS_LOG2)'(hm1);
		c.x0 = scaled_u[FRAC_BITS +: COLS_LOG2];
		c.y0 = scaled_v[FRAC_BITS +: ROWS_LOG2];
		c.tx = scaled_u[FRAC_BITS-1:0];
		c.ty = scaled_v[FRAC_BITS-1:0];
		c.x1 = (w_sat == DIM_W'(1)) ? c.x0 : c.x0 + COLS_LOG2'(1);
		c.y1 = (h_sat == DIM_W'(1)) ? c.y0 : c.y0 + ROWS_LOG2'(1);
		c.empty = (w_sat == '0) || (h_sat == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coord_s2 <= c;
		end
	end

endmodule

// ----- rtl/bts_filter.sv -----
// Filter stage: steers the four bank outputs to corners, blends horizontally, then vertically.
// Depends on bts_pkg.
`timescale 1ns / 1ps
module bts_filter import bts_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [TEXEL_W-1:0]   bank_data [4],
	input  logic [3:0]           sel_s3,
	input  logic [FRAC_BITS-1:0] tx_s3,
	input  logic [FRAC_BITS-1:0] ty_s3,
	output logic [TEXEL_W-1:0]   rgb
);

	logic [TEXEL_W-1:0]   p00, p10, p01, p11;
	logic [TEXEL_W-1:0]   top_s4, bot_s4;
	logic [FRAC_BITS-1:0] ty_s4;

	// sel_s3: {y1[0], y0[0], x1[0], x0[0]}; bank index is {row parity, col parity}
	always_comb begin
		p00 = bank_data[{sel_s3[2], sel_s3[0]}];
		p10 = bank_data[{sel_s3[2], sel_s3[1]}];
		p01 = bank_data[{sel_s3[3], sel_s3[0]}];
		p11 = bank_data[{sel_s3[3], sel_s3[1]}];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			top_s4 <= lerp_texel(p00, p10, tx_s3);
			bot_s4 <= lerp_texel(p01, p11, tx_s3);
			ty_s4  <= ty_s3;
		end
	end

	assign rgb = lerp_texel(top_s4, bot_s4, ty_s4);

endmodule

// ----- rtl/bilinear_texture_sampler_top.sv -----
// Top level of the bilinear texture sampler: stream ports, pipeline control, texel banks.
// Depends on bts_pkg, bts_ram, bts_coord and bts_filter.
// One item enters per cycle while no result waits at the output. A sample's result
// passes through the input register, coordinate multiply, bank read, horizontal blend
// and the output register, where it is presented. The whole pipeline holds while a
// result waits at the output. The texel store is four banks split by column and row
// parity, so all four neighbours are read together; writes land in the bank read stage,
// keeping item order exact. The store is not cleared: sample only texels that have been written.
`timescale 1ns / 1ps
module bilinear_texture_sampler_top import bts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,  // texel_col, texel_row, in_red, in_green, in_blue, coord_u, coord_v
	input  logic                 s_tuser,  // operation
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,  // out_red, out_green, out_blue
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	logic [DIM_W-1:0]     tex_width_q, tex_height_q;
	logic                 adv;
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic                 op_s1, op_s2;
	logic                 empty_s3, empty_s4;
	logic [COLS_LOG2-1:0] col_s1, col_s2;
	logic [ROWS_LOG2-1:0] row_s1, row_s2;
	logic [TEXEL_W-1:0]   rgb_s1, rgb_s2;
	logic [FRAC_BITS-1:0] fu_s1, fv_s1, tx_s3, ty_s3;
	logic [3:0]           sel_s3;
	coord_t               coord_s2;
	logic [TEXEL_W-1:0]   bank_data [4];
	logic [TEXEL_W-1:0]   rgb_f;
	logic                 out_valid_q;
	logic [M_DATA_W-1:0]  out_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= '0;
			tex_height_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_TEX_WIDTH) begin
				tex_width_q <= cfg_data;
			end
			if (cfg_index == REG_TEX_HEIGHT) begin
				tex_height_q <= cfg_data;
			end
		end
	end

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= s_tvalid;
			v_s2        <= v_s1;
			v_s3        <= v_s2 && (op_s2 == OP_SAMPLE);
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= s_tuser;
			col_s1 <= s_tdata[COLS_LOG2-1:0];
			row_s1 <= s_tdata[8 +: ROWS_LOG2];
			rgb_s1 <= {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
			fu_s1  <= s_tdata[40 +: FRAC_BITS];
			fv_s1  <= s_tdata[72 +: FRAC_BITS];
			op_s2  <= op_s1;
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			rgb_s2 <= rgb_s1;
			empty_s3 <= coord_s2.empty;
			tx_s3    <= coord_s2.tx;
			ty_s3    <= coord_s2.ty;
			sel_s3   <= {coord_s2.y1[0], coord_s2.y0[0], coord_s2.x1[0], coord_s2.x0[0]};
			empty_s4 <= empty_s3;
			if (v_s4) begin
				out_data_q <= empty_s4 ? {MAGENTA[7:0], MAGENTA[15:8], MAGENTA[23:16]}
					: {rgb_f[7:0], rgb_f[15:8], rgb_f[23:16]};
			end
		end
	end

	bts_coord u_coord (
		.clk        (clk),
		.en         (adv),
		.frac_u     (fu_s1),
		.frac_v     (fv_s1),
		.tex_width  (tex_width_q),
		.tex_height (tex_height_q),
		.coord_s2   (coord_s2)
	);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic [1:0] BANK_ID = 2'(b);
		logic                   we, re;
		logic [BANK_AW-1:0]     waddr, raddr;
		logic [COLS_LOG2-2:0]   rcol;
		logic [ROWS_LOG2-2:0]   rrow;
		always_comb begin
			we = adv && v_s2 && (op_s2 == OP_WRITE)
				&& (col_s2[0] == BANK_ID[0]) && (row_s2[0] == BANK_ID[1]);
			waddr = {row_s2[ROWS_LOG2-1:1], col_s2[COLS_LOG2-1:1]};
			rcol = (coord_s2.x0[0] == BANK_ID[0]) ? coord_s2.x0[COLS_LOG2-1:1]
				: coord_s2.x1[COLS_LOG2-1:1];
			rrow = (coord_s2.y0[0] == BANK_ID[1]) ? coord_s2.y0[ROWS_LOG2-1:1]
				: coord_s2.y1[ROWS_LOG2-1:1];
			raddr = {rrow, rcol};
			re = adv && v_s2 && (op_s2 == OP_SAMPLE);
		end
		bts_ram #(.AW(BANK_AW), .DW(TEXEL_W)) u_ram (
			.clk   (clk),
			.we    (we),
			.waddr (waddr),
			.wdata (rgb_s2),
			.re    (re),
			.raddr (raddr),
			.rdata (bank_data[b])
		);
	end

	bts_filter u_filter (
		.clk       (clk),
		.en        (adv),
		.bank_data (bank_data),
		.sel_s3    (sel_s3),
		.tx_s3     (tx_s3),
		.ty_s3     (ty_s3),
		.rgb       (rgb_f)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- rtl/bts_checker.sv -----
// Port-level checker for the bilinear texture sampler, bound to the top level.
// Depends on bts_pkg.
`timescale 1ns / 1ps
module bts_checker import bts_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled although output drains");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

endmodule

bind bilinear_texture_sampler_top bts_checker u_bts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- dv/tb_bilinear_texture_sampler_top.sv -----
// Testbench for the bilinear texture sampler: texel writes and wrapped bilinear samples
// checked against a scoreboard that keeps its own copy of the texel store and dimensions.
// Depends on bts_pkg and bilinear_texture_sampler_top.
`timescale 1ns / 1ps

class colour_scoreboard;
	bit [23:0] texels [int];
	bit [8:0]  width_q;
	bit [8:0]  height_q;
	bit [23:0] pending_colours [$];
	int        mismatches;
	int        results_seen;

	function void set_dim(input bit idx_h, input bit [8:0] val);
		if (idx_h) height_q = val;
		else width_q = val;
	endfunction

	function bit [7:0] blend8(input bit [7:0] a, input bit [7:0] b, input bit [15:0] t);
		bit [25:0] acc;
		acc = 26'(a) * (26'h10000 - 26'(t)) + 26'(b) * 26'(t);
		return acc[23:16];
	endfunction

	function bit [23:0] blend_rgb(input bit [23:0] p, input bit [23:0] q, input bit [15:0] t);
		return {blend8(p[23:16], q[23:16], t), blend8(p[15:8], q[15:8], t),
			blend8(p[7:0], q[7:0], t)};
	endfunction

	function bit [23:0] fetch(input bit [8:0] c, input bit [8:0] r);
		int a;
		a = int'({r[7:0], c[7:0]});
		return texels.exists(a) ? texels[a] : 24'h0;
	endfunction

	function void note_item(input bit op, input bit [103:0] d);
		bit [8:0]  w, h;
		bit [47:0] su, sv;
		bit [8:0]  x0, x1, y0, y1;
		bit [15:0] tx, ty;
		bit [23:0] top_c, bot_c;
		if (op == bts_pkg::OP_WRITE) begin
			texels[{d[15:8], d[7:0]}] = {d[23:16], d[31:24], d[39:32]};
			return;
		end
		w = width_q > 256 ? 9'd256 : width_q;
		h = height_q > 256 ? 9'd256 : height_q;
		if (w == 0 || h == 0) begin
			pending_colours.push_back(24'hFF00FF);
			return;
		end
		su = 48'(d[55:40]) * 48'(w - 1);
		sv = 48'(d[87:72]) * 48'(h - 1);
		x0 = su[24:16];
		y0 = sv[24:16];
		tx = su[15:0];
		ty = sv[15:0];
		x1 = 9'((x0 + 1 < w - 1) ? x0 + 1 : w - 1);
		y1 = 9'((y0 + 1 < h - 1) ? y0 + 1 : h - 1);
		top_c = blend_rgb(fetch(x0, y0), fetch(x1, y0), tx);
		bot_c = blend_rgb(fetch(x0, y1), fetch(x1, y1), tx);
		pending_colours.push_back(blend_rgb(top_c, bot_c, ty));
	endfunction

	function void check_result(input bit [23:0] got);
		bit [23:0] e;
		results_seen++;
		if (pending_colours.size() == 0) begin
			report("unexpected result", 0, got);
			return;
		end
		e = pending_colours.pop_front();
		if (got[7:0] != e[23:16]) report("out_red", e[23:16], got[7:0]);
		if (got[15:8] != e[15:8]) report("out_green", e[15:8], got[15:8]);
		if (got[23:16] != e[7:0]) report("out_blue", e[7:0], got[23:16]);
	endfunction

	function void report(input string what, input int e, input int g);
		$display("MISMATCH %s: expected %0h got %0h", what, e, g);
		mismatches++;
	endfunction
endclass

module tb_bilinear_texture_sampler_top;
	import bts_pkg::*;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 s_tvalid = 0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;
	logic                 s_tuser = 0;
	logic                 m_tvalid;
	logic                 m_tready = 0;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 cfg_valid = 0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]     cfg_data = '0;

	colour_scoreboard board;
	int  cycles;
	bit  quiet_tail;
	int  items_sent;
	bit  written [int];
	int  cur_w, cur_h;

	bilinear_texture_sampler_top u_top (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("timeout");
			$display("*** FAILED ***");
			$finish;
		end
	end

	// output side: sample, then pick the ready for the next cycle
	int stall_left;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) board.check_result(m_tdata);
			if (quiet_tail) m_tready <= 1;
			else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 0;
			end else if ($urandom_range(0, 9) == 0) begin
				stall_left <= $urandom_range(0, 15);
				m_tready <= 0;
			end else m_tready <= 1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == REG_TEX_WIDTH) board.set_dim(1'b0, val);
		else if (idx == REG_TEX_HEIGHT) board.set_dim(1'b1, val);
		@(posedge clk);
	endtask

	task automatic send(input bit op, input logic [S_DATA_W-1:0] d);
		int gap;
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		board.note_item(op, d);
		items_sent++;
	endtask

	task automatic put_texel(input bit [7:0] c, input bit [7:0] r, input bit [23:0] rgb);
		written[{r, c}] = 1;
		send(OP_WRITE, {32'($urandom), 32'($urandom), rgb[7:0], rgb[15:8],
			rgb[23:16], r, c});
	endtask

	task automatic sample(input bit [31:0] u, input bit [31:0] v);
		send(OP_SAMPLE, {v, u, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom)});
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.pending_colours.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// fill every texel the chosen dimensions can reach, then set them
	task automatic set_dims(input int w, input int h);
		int ew, eh;
		drain();
		ew = w > 256 ? 256 : w;
		eh = h > 256 ? 256 : h;
		for (int r = 0; r < eh; r++)
			for (int c = 0; c < ew; c++)
				if (!written.exists({r[7:0], c[7:0]}))
					put_texel(8'(c), 8'(r), 24'($urandom));
		drain();
		write_reg(REG_TEX_WIDTH, DIM_W'(w));
		write_reg(REG_TEX_HEIGHT, DIM_W'(h));
		cur_w = w;
		cur_h = h;
	endtask

	initial begin
		int shapes [6][2];
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty texture gives magenta
		sample(32'h0, 32'h0);
		sample(32'h8000_0000, 32'h7FFF_FFFF);
		drain();
		write_reg(REG_TEX_WIDTH, 9'd4);
		drain();
		sample(32'h1234_5678, 32'h0);
		drain();
		write_reg(REG_TEX_HEIGHT, 9'd1);
		write_reg(2'd2, 9'h1FF);
		write_reg(2'd3, 9'h0AA);
		put_texel(0, 0, 24'hFFFFFF);
		put_texel(1, 0, 24'h000000);
		put_texel(2, 0, 24'h80FF01);
		put_texel(3, 0, 24'h01FE7F);
		put_texel(8'hFF, 8'hFF, 24'hA5A5A5);
		sample(32'h0000_0000, 32'h0);
		sample(32'h0000_FFFF, 32'hFFFF_FFFF);
		sample(32'hFFFF_8000, 32'h8000_0000);
		sample(32'h7FFF_5555, 32'h0000_8000);
		sample(32'h8000_0001, 32'h1234_5678);
		set_dims(1, 1);
		sample(32'hDEAD_BEEF, 32'hCAFE_F00D);
		set_dims(3, 2);
		sample(32'h0000_C000, 32'h0000_FFFF);
		sample(32'hFFFF_0001, 32'h0000_0001);

		shapes = '{'{2, 2}, '{256, 1}, '{511, 2}, '{7, 1}, '{1, 13}, '{5, 9}};
		foreach (shapes[k]) begin
			set_dims(shapes[k][0], shapes[k][1]);
			repeat (120) begin
				if (k == 5 && items_sent > 1200) quiet_tail = 1;
				if ($urandom_range(0, 5) == 0)
					put_texel(8'($urandom_range(0, (cur_w > 256 ? 256 : cur_w) - 1)),
						8'($urandom_range(0, (cur_h > 256 ? 256 : cur_h) - 1)),
						24'($urandom));
				else if ($urandom_range(0, 9) == 0)
					sample({$urandom_range(0, 3) == 0 ? 16'hFFFF : 16'h0,
						$urandom_range(0, 1) ? 16'hFFFF : 16'h0}, 32'($urandom));
				else sample(32'($urandom), 32'($urandom));
			end
			if (k == 2) drain();
		end
		quiet_tail = 1;
		repeat (100) sample(32'($urandom), 32'($urandom));
		drain();
		repeat (20) @(posedge clk);
		if (board.pending_colours.size() != 0)
			board.report("results still expected", board.pending_colours.size(), 0);
		$display("Sent %0d items, checked %0d samples across empty, single, odd and",
			items_sent, board.results_seen);
		$display("256-wide textures, with oversized dimensions and wrapped coordinates.");
		if (board.mismatches == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
